// ===== src/rpo_pkg.sv =====
// Shared types, constants and widths for the raster pixel overlay block.
// Depends on nothing; every other source file imports it.
package rpo_pkg;

    localparam int FRAC_BITS = 16;
    localparam int W         = 32;
    localparam int STEP      = 4;
    localparam int DW        = W + FRAC_BITS;
    localparam int NSTG      = (DW + STEP - 1) / STEP;
    localparam int QW        = NSTG * STEP;
    localparam int IQ_DEPTH  = 4;
    localparam int IQ_AW     = $clog2(IQ_DEPTH);
    localparam int OQ_DEPTH  = 2 ** $clog2(NSTG + 3);
    localparam int OQ_AW     = $clog2(OQ_DEPTH);

    localparam logic [2:0] OP_ADD = 3'd0;
    localparam logic [2:0] OP_SUB = 3'd1;
    localparam logic [2:0] OP_MUL = 3'd2;
    localparam logic [2:0] OP_DIV = 3'd3;
    localparam logic [2:0] OP_MAX = 3'd4;
    localparam logic [2:0] OP_MIN = 3'd5;
    localparam logic [2:0] OP_AVG = 3'd6;
    localparam logic [2:0] OP_COV = 3'd7;

    localparam logic [1:0] REG_OPERATION = 2'd0;
    localparam logic [1:0] REG_NODATA    = 2'd1;
    localparam logic [1:0] REG_ND_EN     = 2'd2;

    localparam logic signed [W-1:0] MAX_W = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] MIN_W = {1'b1, {(W-1){1'b0}}};

    typedef struct packed {
        logic [2:0]          op;
        logic signed [W-1:0] ndval;
        logic                nden;
    } t_cfg;

    typedef struct packed {
        logic signed [W-1:0] a;
        logic signed [W-1:0] b;
        logic [2:0]          op;
        logic                nd;
    } t_item;

    typedef struct packed {
        logic                valid;
        logic [2:0]          op;
        logic                nd;
        logic signed [W-1:0] res;
        logic                sat;
    } t_ctl;

endpackage

// ===== src/rpo_front.sv =====
// Front end: accepts input beats, flags no-data and divide-by-zero cases,
// and holds classified items in a short queue. Depends on rpo_pkg.
module rpo_front import rpo_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_cfg          i_cfg,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [63:0]   s_tdata,   // value_a, value_b
    output logic          o_q_valid,
    output t_item         o_q_item,
    input  logic          i_q_pop
);

    t_item            r_mem [IQ_DEPTH];
    logic [IQ_AW-1:0] r_wptr, r_rptr;
    logic [IQ_AW:0]   r_cnt;
    t_item            n_item;
    logic             push;

    assign s_tready  = (r_cnt != IQ_DEPTH[IQ_AW:0]);
    assign push      = s_tvalid && s_tready;
    assign o_q_valid = (r_cnt != '0);
    assign o_q_item  = r_mem[r_rptr];

    always_comb begin
        n_item.a  = s_tdata[31:0];
        n_item.b  = s_tdata[63:32];
        n_item.op = i_cfg.op;
        n_item.nd = (i_cfg.nden && (n_item.a == i_cfg.ndval || n_item.b == i_cfg.ndval))
                    || (i_cfg.op == OP_DIV && n_item.b == '0);
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wptr] <= n_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_q_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            r_cnt <= r_cnt + (IQ_AW+1)'(push) - (IQ_AW+1)'(i_q_pop);
        end
    end

endmodule

// ===== src/rpo_div.sv =====
// Pipelined restoring divider of magnitudes, STEP quotient bits per stage.
// Depends on rpo_pkg.
module rpo_div import rpo_pkg::*; (
    input  logic          i_clk,
    input  logic [W-1:0]  i_num,
    input  logic [W-1:0]  i_den,
    input  logic          i_neg,
    output logic [QW-1:0] o_quo,
    output logic          o_neg
);

    logic [W-1:0]  r_rem [NSTG];
    logic [QW-1:0] r_n   [NSTG];
    logic [W-1:0]  r_d   [NSTG];
    logic          r_neg [NSTG];

    genvar g;
    generate
        for (g = 0; g < NSTG; g++) begin : g_stg
            logic [W-1:0]  rem_in, n_rem;
            logic [QW-1:0] n_in, n_n;
            logic [W-1:0]  d_in;
            logic          neg_in;

            if (g == 0) begin : g_first
                assign rem_in = '0;
                assign n_in   = QW'({i_num, {FRAC_BITS{1'b0}}});
                assign d_in   = i_den;
                assign neg_in = i_neg;
            end else begin : g_next
                assign rem_in = r_rem[g-1];
                assign n_in   = r_n[g-1];
                assign d_in   = r_d[g-1];
                assign neg_in = r_neg[g-1];
            end

            always_comb begin
                logic [W:0] t;
                n_rem = rem_in;
                n_n   = n_in;
                for (int k = 0; k < STEP; k++) begin
                    t   = {n_rem, n_n[QW-1]};
                    n_n = {n_n[QW-2:0], 1'b0};
                    if (t >= {1'b0, d_in}) begin
                        t      = t - {1'b0, d_in};
                        n_n[0] = 1'b1;
                    end
                    n_rem = t[W-1:0];
                end
            end

            always_ff @(posedge i_clk) begin
                r_rem[g] <= n_rem;
                r_n[g]   <= n_n;
                r_d[g]   <= d_in;
                r_neg[g] <= neg_in;
            end
        end
    endgenerate

    assign o_quo = r_n[NSTG-1];
    assign o_neg = r_neg[NSTG-1];

endmodule

// ===== src/rpo_back.sv =====
// Back end: execution pipeline for all operations and the output queue
// with credit-based admission from the front queue. Depends on rpo_pkg, rpo_div.
module rpo_back import rpo_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_cfg          i_cfg,
    input  logic          i_q_valid,
    input  t_item         i_q_item,
    output logic          o_q_pop,
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [31:0]   m_tdata,   // result_value
    output logic [1:0]    m_tuser    // is_nodata, saturated
);

    t_ctl                r_ctl [NSTG+1];
    logic signed [W-1:0] r_a0, r_b0;
    logic signed [63:0]  r_prod;
    logic [QW-1:0]       quo;
    logic                qneg;
    t_ctl                n_s1, n_s2, fin;
    logic [W+1:0]        rd_word;

    logic [W+1:0]        ow_mem [OQ_DEPTH];
    logic [OQ_AW-1:0]    r_wptr, r_rptr;
    logic [OQ_AW:0]      r_cnt, r_credit;
    logic                deq;

    assign o_q_pop = i_q_valid && (r_credit != '0);
    assign deq     = m_tvalid && m_tready;

    rpo_div u_div (
        .i_clk (i_clk),
        .i_num (r_a0[W-1] ? W'(-r_a0) : W'(r_a0)),
        .i_den (r_b0[W-1] ? W'(-r_b0) : W'(r_b0)),
        .i_neg (r_a0[W-1] ^ r_b0[W-1]),
        .o_quo (quo),
        .o_neg (qneg)
    );

    always_comb begin
        logic signed [W:0] s;
        s        = '0;
        n_s1     = r_ctl[0];
        n_s1.sat = 1'b0;
        n_s1.res = '0;
        unique case (r_ctl[0].op)
            OP_ADD, OP_SUB: begin
                s = (r_ctl[0].op == OP_ADD) ? (W+1)'(r_a0) + (W+1)'(r_b0)
                                            : (W+1)'(r_a0) - (W+1)'(r_b0);
                if (s[W] != s[W-1]) begin
                    n_s1.sat = 1'b1;
                    n_s1.res = s[W] ? MIN_W : MAX_W;
                end else begin
                    n_s1.res = s[W-1:0];
                end
            end
            OP_MAX: n_s1.res = (r_a0 > r_b0) ? r_a0 : r_b0;
            OP_MIN: n_s1.res = (r_a0 < r_b0) ? r_a0 : r_b0;
            OP_AVG: begin
                s        = (W+1)'(r_a0) + (W+1)'(r_b0);
                n_s1.res = s[W:1];
            end
            OP_COV: n_s1.res = (r_b0 != i_cfg.ndval && r_b0 != '0) ? r_b0 : r_a0;
            default: n_s1.res = '0;
        endcase
    end

    always_comb begin
        logic signed [63:0] sh;
        n_s2 = r_ctl[1];
        sh   = r_prod >>> FRAC_BITS;
        if (r_ctl[1].op == OP_MUL) begin
            if (sh > 64'(MAX_W)) begin
                n_s2.res = MAX_W;
                n_s2.sat = 1'b1;
            end else if (sh < 64'(MIN_W)) begin
                n_s2.res = MIN_W;
                n_s2.sat = 1'b1;
            end else begin
                n_s2.res = sh[W-1:0];
                n_s2.sat = 1'b0;
            end
        end
    end

    always_comb begin
        logic [W:0] qn;
        fin = r_ctl[NSTG];
        qn  = (W+1)'(-quo[W:0]);
        if (fin.op == OP_DIV) begin
            if (qneg) begin
                if (quo > QW'({1'b1, {(W-1){1'b0}}})) begin
                    fin.res = MIN_W;
                    fin.sat = 1'b1;
                end else begin
                    fin.res = qn[W-1:0];
                    fin.sat = 1'b0;
                end
            end else begin
                if (quo > QW'(MAX_W)) begin
                    fin.res = MAX_W;
                    fin.sat = 1'b1;
                end else begin
                    fin.res = quo[W-1:0];
                    fin.sat = 1'b0;
                end
            end
        end
        if (fin.nd) begin
            fin.res = i_cfg.ndval;
            fin.sat = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a0   <= i_q_item.a;
        r_b0   <= i_q_item.b;
        r_prod <= 64'(r_a0) * 64'(r_b0);
        if (fin.valid) begin
            ow_mem[r_wptr] <= {fin.sat, fin.nd, fin.res};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i <= NSTG; i++) begin
                r_ctl[i] <= '0;
            end
            r_wptr   <= '0;
            r_rptr   <= '0;
            r_cnt    <= '0;
            r_credit <= OQ_DEPTH[OQ_AW:0];
        end else begin
            r_ctl[0].valid <= o_q_pop;
            r_ctl[0].op    <= i_q_item.op;
            r_ctl[0].nd    <= i_q_item.nd;
            r_ctl[0].res   <= '0;
            r_ctl[0].sat   <= 1'b0;
            r_ctl[1]       <= n_s1;
            r_ctl[2]       <= n_s2;
            for (int i = 3; i <= NSTG; i++) begin
                r_ctl[i] <= r_ctl[i-1];
            end
            if (fin.valid) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (deq) begin
                r_rptr <= r_rptr + 1'b1;
            end
            r_cnt    <= r_cnt + (OQ_AW+1)'(fin.valid) - (OQ_AW+1)'(deq);
            r_credit <= r_credit - (OQ_AW+1)'(o_q_pop) + (OQ_AW+1)'(deq);
        end
    end

    assign rd_word  = ow_mem[r_rptr];
    assign m_tvalid = (r_cnt != '0);
    assign m_tdata  = rd_word[W-1:0];
    assign m_tuser  = rd_word[W+1:W];

endmodule

// ===== src/raster_pixel_overlay_alu.sv =====
// Raster pixel overlay ALU: one result pixel per pair of input pixels.
// The pipelined divider (four quotient bits per stage, 12 stages) sets the
// depth from an accepted input beat to its output beat. Throughput is one beat
// per cycle while m_axis_tready stays high. Reset is synchronous and active low;
// it empties both queues and sets all configuration registers to zero.
// Depends on rpo_pkg, rpo_front, rpo_back.
module raster_pixel_overlay_alu import rpo_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_addr,
    input  logic [31:0] i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // value_a, value_b
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // result_value
    output logic [1:0]  m_axis_tuser    // is_nodata, saturated
);

    t_cfg  r_cfg;
    logic  q_valid, q_pop;
    t_item q_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                REG_OPERATION: r_cfg.op    <= i_cfg_wdata[2:0];
                REG_NODATA:    r_cfg.ndval <= i_cfg_wdata;
                REG_ND_EN:     r_cfg.nden  <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    rpo_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .s_tvalid  (s_axis_tvalid),
        .s_tready  (s_axis_tready),
        .s_tdata   (s_axis_tdata),
        .o_q_valid (q_valid),
        .o_q_item  (q_item),
        .i_q_pop   (q_pop)
    );

    rpo_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_q_valid (q_valid),
        .i_q_item  (q_item),
        .o_q_pop   (q_pop),
        .m_tvalid  (m_axis_tvalid),
        .m_tready  (m_axis_tready),
        .m_tdata   (m_axis_tdata),
        .m_tuser   (m_axis_tuser)
    );

endmodule
